[sv/ssll_pkg.sv]
// Shared constants, types and helpers for the sorted slot-list block.
`timescale 1ns / 1ps

package ssll_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int LINK_W  = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int OP_W    = 3;
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 7;

  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(ENTRIES);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_COUNT  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // Request from the controller to the link store.
  typedef struct packed {
    logic              clr;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [LINK_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } link_req_t;

  function automatic logic is_slot(input logic [LINK_W-1:0] l);
    return l < NONE_LINK;
  endfunction

endpackage

[sv/sorted_static_linked_list.sv]
// Top level: sorted key list kept in slot memories, with walk and relink control.
`timescale 1ns / 1ps
// Count, clear and unused op codes answer in the cycle after the transfer.
// Insert, delete and search walk the key chain one slot per cycle, reading key and
// link memories together; insert then passes through relink states S_INS1, S_INS2
// and delete through S_DEL1, S_DEL2, the second only when the slot has a predecessor.
// Reset (synchronous, active high) empties the list; link valid bits clear at once.
// Results are strobed on done for one cycle; the receiver cannot stall.

module sorted_static_linked_list
  import ssll_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         op,
  input  logic signed [KEY_W-1:0] key,
  output logic                    done,
  output logic                    ok,
  output logic [SLOT_W-1:0]       slot,
  output logic [CNT_W-1:0]        entry_count
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WALK = 6'b000010,
    S_INS1 = 6'b000100,
    S_INS2 = 6'b001000,
    S_DEL1 = 6'b010000,
    S_DEL2 = 6'b100000
  } state_t;

  state_t state, state_next;

  // Request held for the length of the walk.
  logic [OP_W-1:0]         op_q;
  logic signed [KEY_W-1:0] key_q;

  // Chain heads and fill count.
  logic [LINK_W-1:0] list_head, list_head_next;
  logic [LINK_W-1:0] free_head, free_head_next;
  logic [LINK_W-1:0] held_count, held_count_next;

  // Walk position: cur is the slot being read, prev the last slot below the key.
  logic [LINK_W-1:0] cur, cur_next;
  logic [LINK_W-1:0] prev, prev_next;
  logic [LINK_W-1:0] steps, steps_next;
  logic [LINK_W-1:0] at, at_next;
  logic [LINK_W-1:0] at_link, at_link_next;

  logic              done_next;
  logic              ok_next;
  logic [SLOT_W-1:0] slot_next;

  // Memory ports.
  link_req_t         link_req;
  logic [LINK_W-1:0] link_rd;
  logic              key_we;
  logic [IDX_W-1:0]  key_waddr;
  logic [KEY_W-1:0]  key_rd;
  logic signed [KEY_W-1:0] key_rd_s;

  logic              accept;
  logic [OP_W-1:0]   op_cur;
  logic              walk_done;
  logic              found;
  logic [LINK_W-1:0] at_c;
  logic [LINK_W-1:0] prev_c;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign op_cur   = (state == S_IDLE) ? op : op_q;
  assign key_rd_s = $signed(key_rd);

  ssll_ram #(
    .WIDTH(KEY_W),
    .DEPTH(ENTRIES)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(key_waddr),
    .wdata(key_q),
    .raddr(link_req.raddr),
    .rdata(key_rd)
  );

  ssll_link_store u_links (
    .clk  (clk),
    .rst  (rst),
    .req  (link_req),
    .rdata(link_rd)
  );

  always_comb begin
    state_next      = state;
    list_head_next  = list_head;
    free_head_next  = free_head;
    held_count_next = held_count;
    cur_next        = cur;
    prev_next       = prev;
    steps_next      = steps;
    at_next         = at;
    at_link_next    = at_link;
    done_next       = 1'b0;
    ok_next         = 1'b0;
    slot_next       = '0;

    link_req        = '0;
    key_we          = 1'b0;
    key_waddr       = free_head[IDX_W-1:0];

    walk_done       = 1'b0;
    found           = 1'b0;
    at_c            = NONE_LINK;
    prev_c          = prev;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op) inside
            OP_INSERT, OP_DELETE, OP_SEARCH: begin
              if (op == OP_INSERT && !is_slot(free_head)) begin
                // Full list: fail at once.
                done_next = 1'b1;
              end else begin
                prev_next  = NONE_LINK;
                prev_c     = NONE_LINK;
                steps_next = '0;
                cur_next   = list_head;
                if (is_slot(list_head)) begin
                  link_req.raddr = list_head[IDX_W-1:0];
                  state_next     = S_WALK;
                end else begin
                  walk_done = 1'b1;
                end
              end
            end
            OP_COUNT: begin
              done_next = 1'b1;
              ok_next   = 1'b1;
            end
            OP_CLEAR: begin
              link_req.clr    = 1'b1;
              list_head_next  = NONE_LINK;
              free_head_next  = '0;
              held_count_next = '0;
              done_next       = 1'b1;
              ok_next         = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_WALK: begin
        // Advance while the slot key is below the request key.
        if (steps < LINK_W'(ENTRIES) && key_rd_s < key_q) begin
          prev_next  = cur;
          prev_c     = cur;
          cur_next   = link_rd;
          steps_next = steps + LINK_W'(1);
          if (is_slot(link_rd)) begin
            link_req.raddr = link_rd[IDX_W-1:0];
          end else begin
            walk_done = 1'b1;
          end
        end else begin
          walk_done = 1'b1;
          at_c      = cur;
          found     = (key_rd_s == key_q);
        end
      end
      S_INS1: begin
        // Take the free head, point it at the successor, and pop the free chain.
        link_req.we     = 1'b1;
        link_req.waddr  = free_head[IDX_W-1:0];
        link_req.wdata  = at;
        key_we          = 1'b1;
        key_waddr       = free_head[IDX_W-1:0];
        free_head_next  = link_rd;
        held_count_next = held_count + LINK_W'(1);
        at_next         = free_head;
        if (is_slot(prev)) begin
          state_next = S_INS2;
        end else begin
          list_head_next = free_head;
          done_next      = 1'b1;
          ok_next        = 1'b1;
          slot_next      = SLOT_W'(free_head[IDX_W-1:0]);
          state_next     = S_IDLE;
        end
      end
      S_INS2: begin
        link_req.we    = 1'b1;
        link_req.waddr = prev[IDX_W-1:0];
        link_req.wdata = at;
        done_next      = 1'b1;
        ok_next        = 1'b1;
        slot_next      = SLOT_W'(at[IDX_W-1:0]);
        state_next     = S_IDLE;
      end
      S_DEL1: begin
        // Push the freed slot on the front of the free chain.
        link_req.we    = 1'b1;
        link_req.waddr = at[IDX_W-1:0];
        link_req.wdata = free_head;
        free_head_next = at;
        if (held_count != '0) begin
          held_count_next = held_count - LINK_W'(1);
        end
        if (is_slot(prev)) begin
          state_next = S_DEL2;
        end else begin
          list_head_next = at_link;
          done_next      = 1'b1;
          ok_next        = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_DEL2: begin
        link_req.we    = 1'b1;
        link_req.waddr = prev[IDX_W-1:0];
        link_req.wdata = at_link;
        done_next      = 1'b1;
        ok_next        = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Walk finished: decide by operation.
    if (walk_done) begin
      prev_next = prev_c;
      at_next   = at_c;
      case (op_cur)
        OP_INSERT: begin
          if (found) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            // Fetch the link of the free head for the pop.
            link_req.raddr = free_head[IDX_W-1:0];
            state_next     = S_INS1;
          end
        end
        OP_DELETE: begin
          if (found) begin
            at_link_next = link_rd;
            state_next   = S_DEL1;
          end else begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        end
        default: begin
          done_next  = 1'b1;
          ok_next    = found;
          slot_next  = found ? SLOT_W'(at_c[IDX_W-1:0]) : '0;
          state_next = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      list_head  <= NONE_LINK;
      free_head  <= '0;
      held_count <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      list_head  <= list_head_next;
      free_head  <= free_head_next;
      held_count <= held_count_next;
      done       <= done_next;
    end
  end

  // Payload registers: hold the request and walk position, load the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= op;
      key_q <= key;
    end
    cur         <= cur_next;
    prev        <= prev_next;
    steps       <= steps_next;
    at          <= at_next;
    at_link     <= at_link_next;
    ok          <= ok_next;
    slot        <= slot_next;
    entry_count <= CNT_W'(held_count_next);
  end

endmodule

[sv/ssll_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module ssll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/ssll_link_store.sv]
// Link memory with per-slot valid bits; an unwritten slot reads as its reset link.
`timescale 1ns / 1ps

module ssll_link_store
  import ssll_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  link_req_t         req,
  output logic [LINK_W-1:0] rdata
);

  logic [ENTRIES-1:0] valid;
  logic               valid_rd;
  logic [IDX_W-1:0]   raddr_rd;
  logic [LINK_W-1:0]  ram_rd;

  ssll_ram #(
    .WIDTH(LINK_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (req.we),
    .waddr(req.waddr),
    .wdata(req.wdata),
    .raddr(req.raddr),
    .rdata(ram_rd)
  );

  // Drop all valid bits on reset or clear: every slot falls back to i+1.
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    valid_rd <= valid[req.raddr];
    raddr_rd <= req.raddr;
  end

  assign rdata = valid_rd ? ram_rd : (LINK_W'(raddr_rd) + LINK_W'(1));

endmodule

[verif/tb.sv]
// Testbench for the sorted slot-list block: queued driver, strobe monitor, in-bench predictor.
`timescale 1ns / 1ps

module tb;
  import ssll_pkg::*;

  // Op codes outside the defined set; the block answers them with a failed result.
  localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

  localparam int CLK_HALF   = 4;
  localparam int DRAIN_CYC  = ENTRIES + 16;
  localparam int CYCLE_CAP  = 1_000_000;
  localparam int POOL_SIZE  = 72;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;
    int unsigned             idle_pct;
  } list_req_t;

  typedef struct {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  cnt;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [OP_W-1:0]         op = '0;
  logic signed [KEY_W-1:0] key = '0;
  logic                    done;
  logic                    ok;
  logic [SLOT_W-1:0]       slot;
  logic [CNT_W-1:0]        entry_count;

  sorted_static_linked_list u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .key         (key),
    .done        (done),
    .ok          (ok),
    .slot        (slot),
    .entry_count (entry_count)
  );

  // Shadow copy of the list: key and link per slot, chain heads, key count.
  logic signed [KEY_W-1:0] shadow_key [ENTRIES];
  logic [LINK_W-1:0]       shadow_link [ENTRIES];
  logic [LINK_W-1:0]       shadow_head;
  logic [LINK_W-1:0]       shadow_free;
  int                      shadow_held;

  list_req_t               pending_q [$];
  list_result_t            expected_q [$];
  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

  list_req_t    next_req;
  list_result_t got_exp;
  int           total_reqs = 0;
  int           accepted = 0;
  int           errors = 0;
  int           cycles = 0;

  // Restore both chains: every slot free in index order, key chain empty.
  function automatic void relink_all();
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_link[i] = (i + 1 < ENTRIES) ? LINK_W'(i + 1) : NONE_LINK;
    end
    shadow_head = NONE_LINK;
    shadow_free = '0;
    shadow_held = 0;
  endfunction

  // Walk the key chain to the first key not below k; hand back it and its predecessor.
  function automatic void walk_to(input logic signed [KEY_W-1:0] k,
                                  output logic [LINK_W-1:0] prev,
                                  output logic [LINK_W-1:0] at);
    int steps;
    steps = 0;
    prev  = NONE_LINK;
    at    = shadow_head;
    while (at < NONE_LINK && steps < ENTRIES && shadow_key[at[IDX_W-1:0]] < k) begin
      prev = at;
      at   = shadow_link[at[IDX_W-1:0]];
      steps++;
    end
    if (at >= NONE_LINK) at = NONE_LINK;
  endfunction

  // Apply one request to the shadow list and return the result it must produce.
  function automatic list_result_t apply_request(input logic [OP_W-1:0] opc,
                                                 input logic signed [KEY_W-1:0] k);
    list_result_t      r;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] at;
    logic [LINK_W-1:0] n;
    r.ok   = 1'b0;
    r.slot = '0;
    case (opc)
      OP_INSERT: begin
        if (shadow_free < NONE_LINK) begin
          walk_to(k, prev, at);
          if (!(at < NONE_LINK && shadow_key[at[IDX_W-1:0]] == k)) begin
            n           = shadow_free;
            shadow_free = shadow_link[n[IDX_W-1:0]];
            shadow_key[n[IDX_W-1:0]] = k;
            if (prev < NONE_LINK) begin
              shadow_link[n[IDX_W-1:0]]    = shadow_link[prev[IDX_W-1:0]];
              shadow_link[prev[IDX_W-1:0]] = n;
            end else begin
              shadow_link[n[IDX_W-1:0]] = shadow_head;
              shadow_head               = n;
            end
            shadow_held++;
            r.ok   = 1'b1;
            r.slot = n[SLOT_W-1:0];
          end
        end
      end
      OP_DELETE: begin
        walk_to(k, prev, at);
        if (at < NONE_LINK && shadow_key[at[IDX_W-1:0]] == k) begin
          if (prev < NONE_LINK) shadow_link[prev[IDX_W-1:0]] = shadow_link[at[IDX_W-1:0]];
          else shadow_head = shadow_link[at[IDX_W-1:0]];
          shadow_link[at[IDX_W-1:0]] = shadow_free;
          shadow_free                = at;
          if (shadow_held > 0) shadow_held--;
          r.ok = 1'b1;
        end
      end
      OP_SEARCH: begin
        walk_to(k, prev, at);
        if (at < NONE_LINK && shadow_key[at[IDX_W-1:0]] == k) begin
          r.ok   = 1'b1;
          r.slot = at[SLOT_W-1:0];
        end
      end
      OP_COUNT: r.ok = 1'b1;
      OP_CLEAR: begin
        relink_all();
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.cnt = CNT_W'(shadow_held);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  task automatic add_req(input logic [OP_W-1:0] opc, input logic signed [KEY_W-1:0] k,
                         input int unsigned idle);
    list_req_t r;
    r.op       = opc;
    r.key      = k;
    r.idle_pct = idle;
    pending_q.push_back(r);
    total_reqs++;
  endtask

  // Mostly pool keys so hits, duplicates and a full list happen; some full-range keys.
  function automatic logic signed [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] OP_T_UNUSED();
    return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
  endfunction

  // Queue one phase of random requests; weights are percent, the rest go to count
  // and a small share to unused op codes.
  task automatic add_phase(input int count, input int unsigned idle, input int w_ins,
                           input int w_del, input int w_srch, input int w_clr);
    int roll;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < w_ins) add_req(OP_INSERT, pick_key(), idle);
      else if (roll < w_ins + w_del) add_req(OP_DELETE, pick_key(), idle);
      else if (roll < w_ins + w_del + w_srch) add_req(OP_SEARCH, pick_key(), idle);
      else if (roll < w_ins + w_del + w_srch + w_clr) add_req(OP_CLEAR, $urandom, idle);
      else if (roll < 98) add_req(OP_COUNT, $urandom, idle);
      else add_req(OP_T_UNUSED(), $urandom, idle);
    end
  endtask

  // Free-running clock, 8 ns period.
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Cycle guard: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Driver: record the transfer when start meets a free block, then present the next
  // request or drop start for an idle cycle. Hold the request while busy.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_q.push_back(apply_request(op, key));
        accepted <= accepted + 1;
      end
      if (!start || !busy) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= pending_q[0].idle_pct) begin
          next_req = pending_q.pop_front();
          start <= 1'b1;
          op    <= next_req.op;
          key   <= next_req.key;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest outstanding expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request outstanding, slot", slot, 0);
      end else begin
        got_exp = expected_q.pop_front();
        if (ok !== got_exp.ok) report_mismatch("ok", ok, got_exp.ok);
        if (slot !== got_exp.slot) report_mismatch("slot", slot, got_exp.slot);
        if (entry_count !== got_exp.cnt)
          report_mismatch("entry_count", entry_count, got_exp.cnt);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    relink_all();
    for (int i = 0; i < ENTRIES; i++) shadow_key[i] = '0;

    // Directed: key extremes, each op, duplicates, absent keys, unused codes, clear.
    add_req(OP_COUNT,  32'sd0, 0);
    add_req(OP_SEARCH, 32'sd0, 0);                 // search of an empty list
    add_req(OP_DELETE, 32'sd5, 0);                 // delete of an empty list
    add_req(OP_INSERT, 32'sh7FFF_FFFF, 0);
    add_req(OP_INSERT, 32'sh8000_0000, 0);         // goes ahead of the head
    add_req(OP_INSERT, 32'sd0, 0);                 // lands mid-chain
    add_req(OP_INSERT, -32'sd1, 0);
    add_req(OP_INSERT, 32'sd0, 0);                 // duplicate
    add_req(OP_INSERT, 32'sh7FFF_FFFF, 0);         // duplicate at the tail
    add_req(OP_SEARCH, 32'sh7FFF_FFFF, 0);
    add_req(OP_SEARCH, 32'sh8000_0000, 0);
    add_req(OP_SEARCH, 32'sd1, 0);                 // absent
    add_req(OP_DELETE, 32'sh8000_0000, 0);         // unlink the head
    add_req(OP_DELETE, 32'sh7FFF_FFFF, 0);         // unlink the tail
    add_req(OP_DELETE, 32'sh7FFF_FFFF, 0);         // already gone
    add_req(OP_INSERT, 32'sd42, 0);                // reuses a freed slot
    add_req(OP_COUNT,  32'shFFFF_FFFF, 0);
    add_req(OP_UNUSED_LO, 32'sd0, 0);
    add_req(OP_UNUSED_HI, -32'sd1, 0);
    add_req(OP_UNUSED_MID, 32'sd42, 0);
    add_req(OP_CLEAR, 32'sh5A5A_A5A5, 0);
    add_req(OP_SEARCH, 32'sd42, 0);                // gone after clear
    add_req(OP_INSERT, 32'sd42, 0);                // slot 0 again
    add_req(OP_COUNT,  32'sd0, 0);

    // Random phases: mixed with no gaps, fill to full with heavy gaps, drain with
    // moderate gaps, refill with no gaps, then mixed with heavy gaps.
    add_phase(250, 0, 40, 20, 25, 3);
    add_phase(300, 80, 75, 5, 15, 0);
    add_phase(250, 32, 15, 55, 25, 1);
    add_phase(250, 0, 70, 8, 18, 0);
    add_phase(150, 80, 35, 25, 30, 4);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to transfer and every result to arrive, then drain.
    do @(negedge clk); while (accepted != total_reqs || expected_q.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
